FILE: src/evs_pkg.sv
// types, constants and helpers shared by the event sequencer modules
package evs_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_PLAY_MUS  = 3'd1,
    CMD_STOP_MUS  = 3'd2,
    CMD_PLAY_EFF  = 3'd3,
    CMD_LOAD      = 3'd4,
    CMD_NOTE_MIX  = 3'd5,
    CMD_READ_MIX  = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_M_CHK   = 17'h00002,
    ST_M_N     = 17'h00004,
    ST_M_OFF0  = 17'h00008,
    ST_M_OFF1  = 17'h00010,
    ST_M_LWAIT = 17'h00020,
    ST_W_REG   = 17'h00040,
    ST_W_VAL   = 17'h00080,
    ST_W_END   = 17'h00100,
    ST_W_WAIT  = 17'h00200,
    ST_STOP    = 17'h00400,
    ST_E_CHK   = 17'h00800,
    ST_E_N     = 17'h01000,
    ST_E_END0  = 17'h02000,
    ST_E_END1  = 17'h04000,
    ST_REPORT  = 17'h08000,
    ST_FLUSH   = 17'h10000
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] chip_register;
    logic [7:0] chip_value;
    logic [7:0] mixer_report;
  } res_t;

  typedef struct packed {
    logic push_rdy;
    logic hold_v;
  } emit_stat_t;

  localparam logic       KIND_WRITE  = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;
  localparam logic [7:0] REG_MIXER   = 8'd7;
  localparam logic [7:0] REG_AMP_A   = 8'd8;
  localparam logic [7:0] REG_AMP_B   = 8'd9;
  localparam logic [7:0] REG_AMP_C   = 8'd10;
  localparam logic [7:0] MIX_RESET   = 8'h3F;
  localparam logic [7:0] CBITS_MASK  = 8'h24;
  localparam logic [7:0] CBITS_KEEP  = 8'hDB;
  localparam logic [7:0] BIT6_CLEAR  = 8'hBF;
  localparam logic [7:0] N_END       = 8'h00;
  localparam logic [7:0] N_LOOP      = 8'hFF;

  // mixer merge: bit 6 cleared, channel c bits owned by a running effect
  function automatic logic [7:0] mix_merge(input logic [7:0] val, input logic eff_on,
                                           input logic [7:0] cbits);
    logic [7:0] v;
    v = val & BIT6_CLEAR;
    if (eff_on) begin
      v = (v & CBITS_KEEP) | (cbits & CBITS_MASK);
    end
    return v;
  endfunction

endpackage

FILE: src/psg_event_sequencer_top.sv
// top level of the sound-chip event sequencer: control sequencer and player state
// a tick reads the store one byte at a time through its single read port
// one command at a time: the input stalls until the sequencer is idle again
// results leave through a one-beat holding stage and an output register
// reset: asynchronous active low, clears players and mixer; store contents undefined
module psg_event_sequencer_top #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_WRITES  = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [11:0] address_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] chip_register_o,
  output logic [7:0] chip_value_o,
  output logic [7:0] mixer_report_o,
  output logic       last_o
);
  import evs_pkg::*;

  localparam int Aw = $clog2(STORE_DEPTH);
  localparam int Cw = $clog2(MAX_WRITES + 1);
  localparam logic [7:0] MaxW = 8'(MAX_WRITES);

  state_e state_q, state_d;

  // player state
  logic [Aw-1:0] m_base_q, m_base_d, m_ptr_q, m_ptr_d, e_ptr_q, e_ptr_d;
  logic          m_play_q, m_play_d, m_primed_q, m_primed_d, e_act_q, e_act_d;
  logic [7:0]    m_wait_q, m_wait_d, e_wait_q, e_wait_d;
  logic [7:0]    shadow_q, shadow_d, cbits_q, cbits_d;

  // event walk registers
  logic          is_eff_q, is_eff_d, stop_tick_q, stop_tick_d;
  logic [1:0]    stop_idx_q, stop_idx_d;
  logic [7:0]    n_q, n_d, reg_q, reg_d, off_lo_q, off_lo_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic [Aw-1:0] start_q, start_d, a_q, a_d;

  // store ports
  logic          rd_en, wr_en;
  logic [Aw-1:0] rd_addr, in_addr;
  logic [7:0]    rd_data;

  // result path
  logic       push, flush, push_ok;
  res_t       push_beat, out_beat;
  emit_stat_t est;

  logic       in_acc;
  logic [7:0] lim, cnt_next, raw_v, v1, cb_new, wr_v;
  logic [Aw-1:0] ev_end;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_addr  = Aw'(address_i);
  assign push_ok  = push && est.push_rdy;
  assign lim      = (n_q < MaxW) ? n_q : MaxW;
  assign cnt_next = 8'(cnt_q) + 8'd1;
  assign ev_end   = start_q + Aw'({n_q, 1'b0});

  // write data merge: effect owns channel c bits of its own mixer writes
  always_comb begin
    raw_v  = rd_data;
    cb_new = cbits_q;
    v1     = raw_v;
    if (is_eff_q && reg_q == REG_MIXER) begin
      cb_new = raw_v & CBITS_MASK;
      v1     = (shadow_q & CBITS_KEEP) | (raw_v & CBITS_MASK);
    end
    wr_v = (reg_q == REG_MIXER) ? mix_merge(v1, e_act_q, cb_new) : v1;
  end

  always_comb begin
    state_d     = state_q;
    m_base_d    = m_base_q;
    m_ptr_d     = m_ptr_q;
    e_ptr_d     = e_ptr_q;
    m_play_d    = m_play_q;
    m_primed_d  = m_primed_q;
    e_act_d     = e_act_q;
    m_wait_d    = m_wait_q;
    e_wait_d    = e_wait_q;
    shadow_d    = shadow_q;
    cbits_d     = cbits_q;
    is_eff_d    = is_eff_q;
    stop_tick_d = stop_tick_q;
    stop_idx_d  = stop_idx_q;
    n_d         = n_q;
    reg_d       = reg_q;
    off_lo_d    = off_lo_q;
    cnt_d       = cnt_q;
    start_d     = start_q;
    a_d         = a_q;
    rd_en       = 1'b0;
    rd_addr     = a_q;
    wr_en       = 1'b0;
    push        = 1'b0;
    push_beat   = '{kind: KIND_WRITE, chip_register: 8'd0, chip_value: 8'd0,
                    mixer_report: 8'd0};
    flush       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(command_i))
            CMD_TICK: state_d = ST_M_CHK;
            CMD_PLAY_MUS: begin
              if (!(m_play_q && m_base_q == in_addr)) begin
                m_base_d = in_addr;
                m_ptr_d  = in_addr + Aw'(8);
                m_play_d = 1'b1;
                m_wait_d = 8'd0;
              end
            end
            CMD_STOP_MUS: begin
              m_play_d    = 1'b0;
              m_ptr_d     = '0;
              stop_idx_d  = 2'd0;
              stop_tick_d = 1'b0;
              state_d     = ST_STOP;
            end
            CMD_PLAY_EFF: begin
              e_ptr_d  = in_addr + Aw'(4);
              e_act_d  = 1'b1;
              e_wait_d = 8'd0;
            end
            CMD_LOAD:     wr_en    = 1'b1;
            CMD_NOTE_MIX: shadow_d = data_i & BIT6_CLEAR;
            CMD_READ_MIX: state_d  = ST_REPORT;
            default: ;
          endcase
        end
      end

      // music player
      ST_M_CHK: begin
        if (!m_play_q) begin
          state_d = ST_E_CHK;
        end else if (!m_primed_q) begin
          m_primed_d = 1'b1;
          state_d    = ST_E_CHK;
        end else if (m_wait_q != 8'd0) begin
          m_wait_d = m_wait_q - 8'd1;
          state_d  = ST_E_CHK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = m_ptr_q + Aw'(1);
          state_d = ST_M_N;
        end
      end
      ST_M_N: begin
        n_d = rd_data;
        if (rd_data == N_END) begin
          m_play_d    = 1'b0;
          m_ptr_d     = '0;
          stop_idx_d  = 2'd0;
          stop_tick_d = 1'b1;
          state_d     = ST_STOP;
        end else if (rd_data == N_LOOP) begin
          rd_en   = 1'b1;
          rd_addr = m_base_q + Aw'(4);
          state_d = ST_M_OFF0;
        end else begin
          is_eff_d = 1'b0;
          start_d  = m_ptr_q + Aw'(2);
          a_d      = m_ptr_q + Aw'(2);
          cnt_d    = '0;
          rd_en    = 1'b1;
          rd_addr  = m_ptr_q + Aw'(2);
          state_d  = ST_W_REG;
        end
      end
      ST_M_OFF0: begin
        off_lo_d = rd_data;
        rd_en    = 1'b1;
        rd_addr  = m_base_q + Aw'(5);
        state_d  = ST_M_OFF1;
      end
      ST_M_OFF1: begin
        // only the low address bits of the loop offset matter after the wrap
        m_ptr_d = m_base_q + Aw'({rd_data, off_lo_q});
        rd_en   = 1'b1;
        rd_addr = m_base_q + Aw'({rd_data, off_lo_q});
        state_d = ST_M_LWAIT;
      end
      ST_M_LWAIT: begin
        m_wait_d = rd_data;
        state_d  = ST_E_CHK;
      end

      // shared event write walk
      ST_W_REG: begin
        reg_d   = rd_data;
        rd_en   = 1'b1;
        rd_addr = a_q + Aw'(1);
        state_d = ST_W_VAL;
      end
      ST_W_VAL: begin
        push      = 1'b1;
        push_beat = '{kind: KIND_WRITE, chip_register: reg_q, chip_value: wr_v,
                      mixer_report: 8'd0};
        if (push_ok) begin
          if (reg_q == REG_MIXER) begin
            shadow_d = wr_v;
          end
          cbits_d = cb_new;
          cnt_d   = cnt_q + Cw'(1);
          a_d     = a_q + Aw'(2);
          if (cnt_next >= lim) begin
            state_d = ST_W_END;
          end else begin
            rd_en   = 1'b1;
            rd_addr = a_q + Aw'(2);
            state_d = ST_W_REG;
          end
        end
      end
      ST_W_END: begin
        // pointer skips every write of the event, also the dropped ones
        if (is_eff_q) begin
          e_ptr_d = ev_end;
        end else begin
          m_ptr_d = ev_end;
        end
        rd_en   = 1'b1;
        rd_addr = ev_end;
        state_d = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        if (is_eff_q) begin
          e_wait_d = rd_data;
          state_d  = ST_FLUSH;
        end else begin
          m_wait_d = rd_data;
          state_d  = ST_E_CHK;
        end
      end

      // music stop writes: amplitudes off then mixer to its quiet value
      ST_STOP: begin
        push = 1'b1;
        case (stop_idx_q)
          2'd0: push_beat.chip_register = REG_AMP_A;
          2'd1: push_beat.chip_register = REG_AMP_B;
          2'd2: push_beat.chip_register = REG_AMP_C;
          default: begin
            push_beat.chip_register = REG_MIXER;
            push_beat.chip_value    = mix_merge(MIX_RESET, e_act_q, cbits_q);
          end
        endcase
        if (push_ok) begin
          stop_idx_d = stop_idx_q + 2'd1;
          if (stop_idx_q == 2'd3) begin
            shadow_d = mix_merge(MIX_RESET, e_act_q, cbits_q);
            state_d  = stop_tick_q ? ST_E_CHK : ST_FLUSH;
          end
        end
      end

      // effect player
      ST_E_CHK: begin
        if (!e_act_q) begin
          state_d = ST_FLUSH;
        end else if (e_wait_q != 8'd0) begin
          e_wait_d = e_wait_q - 8'd1;
          state_d  = ST_FLUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = e_ptr_q + Aw'(1);
          state_d = ST_E_N;
        end
      end
      ST_E_N: begin
        n_d = rd_data;
        if (rd_data == N_END) begin
          state_d = ST_E_END0;
        end else begin
          is_eff_d = 1'b1;
          start_d  = e_ptr_q + Aw'(2);
          a_d      = e_ptr_q + Aw'(2);
          cnt_d    = '0;
          rd_en    = 1'b1;
          rd_addr  = e_ptr_q + Aw'(2);
          state_d  = ST_W_REG;
        end
      end
      ST_E_END0: begin
        push = 1'b1;
        push_beat.chip_register = REG_AMP_C;
        if (push_ok) begin
          e_act_d = 1'b0;
          cbits_d = CBITS_MASK;
          state_d = ST_E_END1;
        end
      end
      ST_E_END1: begin
        // channel c released, effect no longer active for the merge
        push = 1'b1;
        push_beat.chip_register = REG_MIXER;
        push_beat.chip_value    = mix_merge(shadow_q | CBITS_MASK, 1'b0, cbits_q);
        if (push_ok) begin
          shadow_d = mix_merge(shadow_q | CBITS_MASK, 1'b0, cbits_q);
          state_d  = ST_FLUSH;
        end
      end

      ST_REPORT: begin
        push      = 1'b1;
        push_beat = '{kind: KIND_REPORT, chip_register: 8'd0, chip_value: 8'd0,
                      mixer_report: shadow_q};
        if (push_ok) begin
          state_d = ST_FLUSH;
        end
      end

      // release the held beat with its last flag
      ST_FLUSH: begin
        flush = 1'b1;
        if (!est.hold_v) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_base_q    <= '0;
      m_ptr_q     <= '0;
      e_ptr_q     <= '0;
      m_play_q    <= 1'b0;
      m_primed_q  <= 1'b0;
      e_act_q     <= 1'b0;
      m_wait_q    <= 8'd0;
      e_wait_q    <= 8'd0;
      shadow_q    <= MIX_RESET;
      cbits_q     <= CBITS_MASK;
      is_eff_q    <= 1'b0;
      stop_tick_q <= 1'b0;
      stop_idx_q  <= 2'd0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      m_base_q    <= m_base_d;
      m_ptr_q     <= m_ptr_d;
      e_ptr_q     <= e_ptr_d;
      m_play_q    <= m_play_d;
      m_primed_q  <= m_primed_d;
      e_act_q     <= e_act_d;
      m_wait_q    <= m_wait_d;
      e_wait_q    <= e_wait_d;
      shadow_q    <= shadow_d;
      cbits_q     <= cbits_d;
      is_eff_q    <= is_eff_d;
      stop_tick_q <= stop_tick_d;
      stop_idx_q  <= stop_idx_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    reg_q    <= reg_d;
    off_lo_q <= off_lo_d;
    start_q  <= start_d;
    a_q      <= a_d;
  end

  evs_store #(
    .Depth(STORE_DEPTH),
    .Aw   (Aw)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(in_addr),
    .wdata_i(data_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  evs_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_beat_i(push_beat),
    .flush_i    (flush),
    .stat_o     (est),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat),
    .out_last_o (last_o)
  );

  assign kind_o          = out_beat.kind;
  assign chip_register_o = out_beat.chip_register;
  assign chip_value_o    = out_beat.chip_value;
  assign mixer_report_o  = out_beat.mixer_report;
endmodule

FILE: src/evs_store.sv
// event store: one write port, one registered read port
module evs_store #(
  parameter int Depth = 4096,
  parameter int Aw    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/evs_emit.sv
// result holding stage and output register, marks the last beat on flush
module evs_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  evs_pkg::res_t       push_beat_i,
  input  logic                flush_i,
  output evs_pkg::emit_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output evs_pkg::res_t       out_beat_o,
  output logic                out_last_o
);
  import evs_pkg::*;

  logic hold_v_q, hold_v_d;
  res_t hold_q;
  logic out_v_q, out_v_d;
  res_t out_q;
  logic last_q;
  logic slot_free, push_ok, flush_ok, load_out;

  assign slot_free = !out_v_q || !out_stall_i;
  assign push_ok   = push_i && (!hold_v_q || slot_free);
  assign flush_ok  = flush_i && hold_v_q && slot_free;
  assign load_out  = (push_ok && hold_v_q) || flush_ok;

  always_comb begin
    hold_v_d = hold_v_q;
    out_v_d  = out_v_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (load_out) begin
      out_v_d = 1'b1;
    end
    if (push_ok) begin
      hold_v_d = 1'b1;
    end else if (flush_ok) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      hold_q <= push_beat_i;
    end
    if (load_out) begin
      out_q  <= hold_q;
      last_q <= flush_ok;
    end
  end

  assign stat_o.push_rdy = !hold_v_q || slot_free;
  assign stat_o.hold_v   = hold_v_q;
  assign out_valid_o     = out_v_q;
  assign out_beat_o      = out_q;
  assign out_last_o      = last_q;
endmodule

FILE: tb/sv/psg_event_sequencer_checker.sv
// checker for the event sequencer: predicts register writes and mixer reports from accepted commands
module psg_event_sequencer_checker #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_WRITES  = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  chip_register_i,
  input  logic [7:0]  chip_value_i,
  input  logic [7:0]  mixer_report_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          beats_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import evs_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] chip_register;
    logic [7:0] chip_value;
    logic [7:0] mixer_report;
    logic       last;
  } beat_t;

  logic [7:0]  store_q [STORE_DEPTH];
  logic [11:0] mus_base, mus_ptr, eff_ptr;
  logic        mus_on, mus_primed, eff_on;
  logic [7:0]  mus_wait, eff_wait, mix_shadow, eff_cbits;
  beat_t       expected_beats [$];
  beat_t       step_beats [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_beats.size();

  function automatic logic [7:0] rd(input int unsigned a);
    return store_q[a % STORE_DEPTH];
  endfunction

  function automatic logic [11:0] wrap(input int unsigned a);
    return 12'(a % STORE_DEPTH);
  endfunction

  task automatic put(input logic k, input logic [7:0] r, input logic [7:0] v,
                     input logic [7:0] rep);
    beat_t b;
    b = '{kind: k, chip_register: r, chip_value: v, mixer_report: rep, last: 1'b0};
    if (step_beats.size() < 60) step_beats.push_back(b);
  endtask

  task automatic chip_wr(input logic [7:0] r, input logic [7:0] v);
    logic [7:0] m;
    m = v;
    if (r == REG_MIXER) begin
      m = m & 8'hBF;
      if (eff_on) m = (m & 8'hDB) | (eff_cbits & 8'h24);
      mix_shadow = m;
    end
    put(KIND_WRITE, r, m, 8'h00);
  endtask

  task automatic silence_music();
    mus_on  = 1'b0;
    mus_ptr = '0;
    chip_wr(REG_AMP_A, 8'h00);
    chip_wr(REG_AMP_B, 8'h00);
    chip_wr(REG_AMP_C, 8'h00);
    chip_wr(REG_MIXER, 8'h3F);
  endtask

  task automatic music_frame();
    logic [7:0]  n;
    logic [31:0] off;
    int unsigned w, lim;
    if (!mus_on) return;
    if (!mus_primed) begin
      mus_primed = 1'b1;
      return;
    end
    if (mus_wait > 0) begin
      mus_wait--;
      return;
    end
    n = rd(mus_ptr + 1);
    if (n == N_END) begin
      silence_music();
      return;
    end
    if (n == N_LOOP) begin
      off = {rd(mus_base + 7), rd(mus_base + 6), rd(mus_base + 5), rd(mus_base + 4)};
      mus_ptr  = wrap((mus_base + off) % STORE_DEPTH);
      mus_wait = rd(mus_ptr);
      return;
    end
    w   = wrap(mus_ptr + 2);
    lim = (n < MAX_WRITES) ? n : MAX_WRITES;
    for (int unsigned i = 0; i < lim; i++) chip_wr(rd(w + 2 * i), rd(w + 2 * i + 1));
    mus_ptr  = wrap(w + 2 * n);
    mus_wait = rd(mus_ptr);
  endtask

  task automatic effect_frame();
    logic [7:0]  n, r, v;
    int unsigned w, lim;
    if (!eff_on) return;
    if (eff_wait > 0) begin
      eff_wait--;
      return;
    end
    n = rd(eff_ptr + 1);
    if (n == N_END) begin
      chip_wr(REG_AMP_C, 8'h00);
      eff_on    = 1'b0;
      eff_cbits = 8'h24;
      chip_wr(REG_MIXER, mix_shadow | 8'h24);
      return;
    end
    w   = wrap(eff_ptr + 2);
    lim = (n < MAX_WRITES) ? n : MAX_WRITES;
    for (int unsigned i = 0; i < lim; i++) begin
      r = rd(w + 2 * i);
      v = rd(w + 2 * i + 1);
      if (r == REG_MIXER) begin
        eff_cbits = v & 8'h24;
        v = (mix_shadow & 8'hDB) | (v & 8'h24);
      end
      chip_wr(r, v);
    end
    eff_ptr  = wrap(w + 2 * n);
    eff_wait = rd(eff_ptr);
  endtask

  // one accepted command: update the predicted state and queue its beats
  task automatic sequence_command(input logic [2:0] c, input logic [11:0] a,
                                  input logic [7:0] d);
    logic [11:0] aw;
    beat_t       b;
    aw = wrap(a);
    step_beats.delete();
    case (c)
      CMD_TICK: begin
        music_frame();
        effect_frame();
      end
      CMD_PLAY_MUS: begin
        if (!(mus_on && mus_base == aw)) begin
          mus_base = aw;
          mus_ptr  = wrap(aw + 8);
          mus_on   = 1'b1;
          mus_wait = '0;
        end
      end
      CMD_STOP_MUS: silence_music();
      CMD_PLAY_EFF: begin
        eff_ptr  = wrap(aw + 4);
        eff_on   = 1'b1;
        eff_wait = '0;
      end
      CMD_LOAD:     store_q[aw] = d;
      CMD_NOTE_MIX: mix_shadow = d & 8'hBF;
      CMD_READ_MIX: put(KIND_REPORT, 8'h00, 8'h00, mix_shadow);
      default: ;
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) begin
      b = step_beats[i];
      expected_beats.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t exp_b, got;
    if (!rst_ni) begin
      mus_base = '0; mus_ptr = '0; mus_on = 1'b0; mus_wait = '0; mus_primed = 1'b0;
      eff_ptr = '0; eff_on = 1'b0; eff_wait = '0;
      mix_shadow = 8'h3F; eff_cbits = 8'h24;
      expected_beats.delete();
      fails = 0;
      beats_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{kind_i, chip_register_i, chip_value_i, mixer_report_i, last_i};
        beats_seen_o++;
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected beat %h", got);
        end else begin
          exp_b = expected_beats.pop_front();
          if (got !== exp_b) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: exp kind %0d reg %0d val %h rep %h last %0d",
                       exp_b.kind, exp_b.chip_register, exp_b.chip_value,
                       exp_b.mixer_report, exp_b.last);
              $display("          got kind %0d reg %0d val %h rep %h last %0d",
                       got.kind, got.chip_register, got.chip_value,
                       got.mixer_report, got.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) sequence_command(command_i, address_i, data_i);
    end
  end

endmodule

FILE: tb/sv/psg_event_sequencer_top_tb.sv
// testbench top for the event sequencer: stimulus, idling and verdict
module psg_event_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import evs_pkg::*;

  localparam int TIMEOUT_CYCLES = 1_500_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [11:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o, last_o;
  logic [7:0]  chip_register_o, chip_value_o, mixer_report_o;
  int          fail_count, pending, beats_seen;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          stall_mode = 0;
  int          gap_left = 0;
  int          burst_left = 4;

  always #2 clk_i = ~clk_i;

  psg_event_sequencer_top dut (.*);

  psg_event_sequencer_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .address_i,
    .data_i, .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o),
    .chip_register_i(chip_register_o), .chip_value_i(chip_value_o),
    .mixer_report_i(mixer_report_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .beats_seen_o(beats_seen)
  );

  // receiver stall pattern: long free stretches, light stalling, bursts of heavy stalling
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("psg_event_sequencer_top test failed");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic logic [11:0] rnd12();
    return 12'($urandom_range(0, 4095));
  endfunction

  // one beat on the command channel, with sender gaps between bursts
  task automatic send(input cmd_e c, input logic [11:0] a, input logic [7:0] d);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
      burst_left = int'($urandom_range(1, 10));
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= c;
    address_i  <= a;
    data_i     <= d;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic load(input logic [11:0] a, input logic [7:0] d);
    send(CMD_LOAD, a, d);
  endtask

  // effect stream: a mixer write and a write, a 1-3 or 0xff-count event, end
  task automatic build_effect(input logic [11:0] base, input bit long_evt);
    logic [11:0] p;
    int n;
    for (int i = 0; i < 4; i++) load(12'(base + i), rnd8(0, 255));
    p = base + 12'd4;
    load(p, rnd8(0, 1));
    load(p + 12'd1, 8'd2);
    load(p + 12'd2, REG_MIXER);
    load(p + 12'd3, rnd8(0, 255));
    load(p + 12'd4, rnd8(0, 15));
    load(p + 12'd5, rnd8(0, 255));
    p = p + 12'd6;
    n = long_evt ? 255 : int'($urandom_range(1, 3));
    load(p, 8'd0);
    load(p + 12'd1, 8'(n));
    for (int i = 0; i < (long_evt ? 31 : n); i++) begin
      load(12'(p + 2 + 2 * i), rnd8(0, 15));
      load(12'(p + 3 + 2 * i), rnd8(0, 255));
    end
    // the pointer skips all n pairs, so the end mark sits past the dropped ones
    p = 12'(p + 2 + 2 * n);
    load(p, rnd8(0, 1));
    load(p + 12'd1, N_END);
  endtask

  // music stream at base with a few events and a loop or end mark
  task automatic build_music(input logic [11:0] base, input bit looped, input int nev);
    logic [11:0] p;
    int n;
    // header: loop offset 8 points back at the first event
    for (int i = 0; i < 8; i++) load(12'(base + i), (i == 4) ? 8'd8 : 8'd0);
    p = base + 12'd8;
    for (int e = 0; e < nev; e++) begin
      n = ($urandom_range(0, 5) == 0) ? 32 : int'($urandom_range(1, 4));
      load(p, rnd8(0, 2));
      load(p + 12'd1, 8'(n));
      for (int i = 0; i < n; i++) begin
        load(12'(p + 2 + 2 * i), ($urandom_range(0, 3) == 0) ? REG_MIXER : rnd8(0, 255));
        load(12'(p + 3 + 2 * i), rnd8(0, 255));
      end
      p = 12'(p + 2 + 2 * n);
    end
    load(p, 8'd0);
    load(p + 12'd1, looped ? N_LOOP : N_END);
  endtask

  initial begin
    logic [11:0] mbase, ebase;
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: quiet commands, mixer report extremes, stop while idle
    send(CMD_READ_MIX, 12'hFFF, 8'hFF);
    send(CMD_NOTE_MIX, 12'h000, 8'hFF);
    send(CMD_READ_MIX, 12'h000, 8'h00);
    send(CMD_NOTE_MIX, 12'hFFF, 8'h00);
    send(CMD_TICK, 12'hABC, 8'h55);
    send(CMD_NOP, 12'hFFF, 8'hFF);
    send(CMD_STOP_MUS, 12'h000, 8'h00);
    send(CMD_LOAD, 12'hFFF, 8'hAA);
    send(CMD_READ_MIX, 12'h555, 8'hAA);

    // well-formed sessions, each in a region of its own so that players still
    // running from an earlier session keep walking intact streams; the first
    // one wraps past the top of the store
    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       mbase = 12'hFF0;
        1:       mbase = 12'h200;
        2:       mbase = 12'h600 + 12'(16 * $urandom_range(0, 15));
        default: mbase = 12'hA00 + 12'(16 * $urandom_range(0, 15));
      endcase
      ebase = mbase + 12'h100;
      build_music(mbase, s[0], (s == 0) ? 2 : 1);
      build_effect(ebase, s == 1);
      send(CMD_PLAY_MUS, mbase, rnd8(0, 255));
      send(CMD_PLAY_MUS, mbase, 8'h00);          // same track while playing
      for (int t = 0; t < 14; t++) begin
        r = int'($urandom_range(0, 9));
        if (t == 2) send(CMD_PLAY_EFF, ebase, rnd8(0, 255));
        else if (r == 0) send(CMD_NOTE_MIX, rnd12(), rnd8(0, 255));
        else if (r == 1) send(CMD_READ_MIX, rnd12(), rnd8(0, 255));
        else send(CMD_TICK, rnd12(), rnd8(0, 255));
      end
      if ($urandom_range(0, 1) == 1) send(CMD_STOP_MUS, rnd12(), 8'h00);
    end
    send(CMD_STOP_MUS, 12'h000, 8'h00);
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("sent %0d commands, checked %0d result beats across music and effect sessions",
             items_sent, beats_seen);
    if (fail_count == 0) begin
      $display("psg_event_sequencer_top test passed");
    end else begin
      $display("psg_event_sequencer_top test failed");
    end
    $finish;
  end

endmodule
